>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst_n is high.
`define SSDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that one condition implies another in the next cycle.
`define SSDP_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> design/ssdp_pkg.sv
package ssdp_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int INDEX_BITS_DEF = 20;
  localparam int VALUE_BITS_DEF = 16;
  localparam int SUM_BITS       = 64;
  localparam int ACTION_BITS    = 2;
  localparam int OUT_USER_BITS  = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_APPEND_B = 2'd1,
    ACT_COMPUTE  = 2'd2,
    ACT_UNUSED   = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

>>> design/ssdp_ram.sv
module ssdp_ram #(
  parameter int WIDTH     = 36,
  parameter int DEPTH     = 256,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sparse_sparse_dot_product.sv
// Sparse dot product of two vectors loaded as (index, value) entries.
// Input channel in_*: in_tuser carries the action (append to a, append to b,
// compute), in_tdata the entry index and value. An append stores the entry
// and produces no result; an append to a full store is dropped and flagged.
// A compute transaction walks both entry stores and returns one result on
// out_*: the wrapping 64-bit sum in out_tdata, the merge-path and overflow
// flags in out_tuser. Action code 3 is accepted and ignored.
// A compute steps through the walk, drain and finish states. If both vectors
// are strictly sorted the walk is a merge walk; otherwise it is an all-pairs
// walk. An empty vector skips the walk and the drain state. The walk reads
// one entry of each store per cycle.
// The result sits in an output register; appends keep being accepted while
// it waits, a compute waits at its end until the register is free.
// At reset (rst_n low, synchronous) both vectors are empty, sorted and the
// overflow flag is clear; store contents are not cleared and need no pass.
// After a compute both vectors are empty again.
module sparse_sparse_dot_product
  import ssdp_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int ENTRY_BITS = INDEX_BITS + VALUE_BITS,
  parameter int IN_W       = ((ENTRY_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_W-1:0]          in_tdata,   // entry_index, entry_value, zero pad
  input  logic [ACTION_BITS-1:0]   in_tuser,   // action
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [SUM_BITS-1:0]      out_tdata,  // dot_product
  output logic [OUT_USER_BITS-1:0] out_tuser   // took_merge_path, overflow_seen
);

  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  state_t state_r, state_nxt;
  logic [CW-1:0] a_cnt_r, b_cnt_r, i_r, i_nxt, j_r, j_nxt;
  logic a_sorted_r, b_sorted_r, dropped_r, merge_r;
  logic [INDEX_BITS-1:0] a_last_r, b_last_r;
  logic out_valid_r;
  logic [SUM_BITS-1:0] out_data_r, acc_r;
  logic [OUT_USER_BITS-1:0] out_user_r;
  logic prod_vld_r, prod_en;
  logic signed [2*VALUE_BITS-1:0] prod_r;

  logic in_acc, out_free, a_we, b_we, walk_done;
  action_t act;
  logic [INDEX_BITS-1:0] in_idx, a_idx, b_idx;
  logic [ENTRY_BITS-1:0] a_q, b_q;
  logic signed [VALUE_BITS-1:0] a_val, b_val;

  assign act       = action_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_idx    = in_tdata[INDEX_BITS-1:0];
  assign a_we      = in_acc && (act == ACT_APPEND_A) && (a_cnt_r != FULL);
  assign b_we      = in_acc && (act == ACT_APPEND_B) && (b_cnt_r != FULL);

  assign a_idx = a_q[INDEX_BITS-1:0];
  assign b_idx = b_q[INDEX_BITS-1:0];
  assign a_val = a_q[ENTRY_BITS-1:INDEX_BITS];
  assign b_val = b_q[ENTRY_BITS-1:INDEX_BITS];

  ssdp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH), .ADDR_BITS(AW)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_cnt_r[AW-1:0]),
    .wdata (in_tdata[ENTRY_BITS-1:0]),
    .raddr (i_nxt[AW-1:0]),
    .rdata (a_q)
  );

  ssdp_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH), .ADDR_BITS(AW)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_cnt_r[AW-1:0]),
    .wdata (in_tdata[ENTRY_BITS-1:0]),
    .raddr (j_nxt[AW-1:0]),
    .rdata (b_q)
  );

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    prod_en   = 1'b0;
    walk_done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (act == ACT_COMPUTE)) begin
          if ((a_cnt_r == '0) || (b_cnt_r == '0)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (merge_r) begin
          if (a_idx < b_idx) begin
            i_nxt = CW'(i_r + 1'b1);
          end else if (a_idx > b_idx) begin
            j_nxt = CW'(j_r + 1'b1);
          end else begin
            prod_en = 1'b1;
            i_nxt   = CW'(i_r + 1'b1);
            j_nxt   = CW'(j_r + 1'b1);
          end
          walk_done = (i_nxt >= a_cnt_r) || (j_nxt >= b_cnt_r);
        end else begin
          prod_en = (a_idx == b_idx);
          if (CW'(i_r + 1'b1) == a_cnt_r) begin
            i_nxt     = '0;
            j_nxt     = CW'(j_r + 1'b1);
            walk_done = (j_nxt == b_cnt_r);
          end else begin
            i_nxt = CW'(i_r + 1'b1);
          end
        end
        if (walk_done) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_cnt_r     <= '0;
      b_cnt_r     <= '0;
      a_sorted_r  <= 1'b1;
      b_sorted_r  <= 1'b1;
      a_last_r    <= '0;
      b_last_r    <= '0;
      dropped_r   <= 1'b0;
      merge_r     <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      prod_vld_r <= prod_en;
      if (in_acc) begin
        case (act)
          ACT_APPEND_A: begin
            if (a_cnt_r == FULL) begin
              dropped_r <= 1'b1;
            end else begin
              if ((a_cnt_r != '0) && (in_idx <= a_last_r)) begin
                a_sorted_r <= 1'b0;
              end
              a_last_r <= in_idx;
              a_cnt_r  <= CW'(a_cnt_r + 1'b1);
            end
          end
          ACT_APPEND_B: begin
            if (b_cnt_r == FULL) begin
              dropped_r <= 1'b1;
            end else begin
              if ((b_cnt_r != '0) && (in_idx <= b_last_r)) begin
                b_sorted_r <= 1'b0;
              end
              b_last_r <= in_idx;
              b_cnt_r  <= CW'(b_cnt_r + 1'b1);
            end
          end
          ACT_COMPUTE: begin
            merge_r <= a_sorted_r && b_sorted_r && (a_cnt_r != '0) && (b_cnt_r != '0);
          end
          default: begin
          end
        endcase
      end
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
        a_cnt_r     <= '0;
        b_cnt_r     <= '0;
        a_sorted_r  <= 1'b1;
        b_sorted_r  <= 1'b1;
        a_last_r    <= '0;
        b_last_r    <= '0;
        dropped_r   <= 1'b0;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r <= a_val * b_val;
    end
    if (in_acc && (act == ACT_COMPUTE)) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + SUM_BITS'(prod_r);
    end
    if ((state_r == ST_FINISH) && out_free) begin
      out_data_r <= acc_r;
      out_user_r <= {dropped_r, merge_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `SSDP_ASSERT(a_cnt_in_range, (a_cnt_r <= FULL) && (b_cnt_r <= FULL),
    "entry count beyond store depth")
  `SSDP_ASSERT(walk_ptr_in_range,
    (state_r != ST_WALK) || ((i_r < a_cnt_r) && (j_r < b_cnt_r)),
    "walk pointer outside loaded entries")
  `SSDP_ASSERT(prod_only_after_walk, !prod_vld_r || ($past(state_r) == ST_WALK),
    "product issued outside the walk")
  `SSDP_ASSERT_NEXT(clear_after_result, (state_r == ST_FINISH) && out_free,
    (a_cnt_r == '0) && (b_cnt_r == '0) && !dropped_r && out_valid_r,
    "stores not cleared after result")

endmodule

>>> verif/tb_sparse_sparse_dot_product.sv
module tb_sparse_sparse_dot_product;
  import ssdp_pkg::*;

  localparam int IW   = INDEX_BITS_DEF;
  localparam int VW   = VALUE_BITS_DEF;
  localparam int IN_W = ((IW + VW + 7) / 8) * 8;

  typedef struct {
    action_t        act;
    logic [IW-1:0]  idx;
    logic [VW-1:0]  val;
  } entry_txn_t;

  typedef struct {
    longint dot;
    bit     merged;
    bit     ovf;
  } dot_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_W-1:0]          in_tdata = '0;
  logic [ACTION_BITS-1:0]   in_tuser = ACT_APPEND_A;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [SUM_BITS-1:0]      out_tdata;
  logic [OUT_USER_BITS-1:0] out_tuser;

  sparse_sparse_dot_product DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  entry_txn_t  txn_q[$];
  dot_result_t expected_dots[$];
  entry_txn_t  drv_txn;
  int          send_idle_pct = 26;
  int          recv_idle_pct = 67;
  int          mismatch_count = 0;
  int unsigned stim_count = 0;

  // shadow of both vectors: index 0 is vector a, index 1 is vector b
  logic [IW-1:0]        vec_idx [2][DEPTH_DEF];
  logic signed [VW-1:0] vec_val [2][DEPTH_DEF];
  int                   vec_cnt [2];
  bit                   vec_sorted [2];
  logic [IW-1:0]        vec_last [2];
  bit                   dropped;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1000000);
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 30) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic clear_vectors();
    for (int v = 0; v < 2; v++) begin
      vec_cnt[v]    = 0;
      vec_sorted[v] = 1'b1;
      vec_last[v]   = '0;
    end
    dropped = 1'b0;
  endtask

  task automatic absorb_transaction(input action_t act, input logic [IW-1:0] idx,
                                    input logic signed [VW-1:0] val);
    dot_result_t r;
    int          v;
    int          i;
    int          j;
    case (act)
      ACT_APPEND_A, ACT_APPEND_B: begin
        v = (act == ACT_APPEND_B);
        if (vec_cnt[v] >= DEPTH_DEF) begin
          dropped = 1'b1;
        end else begin
          if (vec_cnt[v] > 0 && idx <= vec_last[v]) vec_sorted[v] = 1'b0;
          vec_idx[v][vec_cnt[v]] = idx;
          vec_val[v][vec_cnt[v]] = val;
          vec_last[v] = idx;
          vec_cnt[v]++;
        end
      end
      ACT_COMPUTE: begin
        r.dot    = 0;
        r.merged = 1'b0;
        r.ovf    = dropped;
        if (vec_cnt[0] != 0 && vec_cnt[1] != 0) begin
          if (vec_sorted[0] && vec_sorted[1]) begin
            r.merged = 1'b1;
            i = 0;
            j = 0;
            while (i < vec_cnt[0] && j < vec_cnt[1]) begin
              if (vec_idx[0][i] < vec_idx[1][j]) begin
                i++;
              end else if (vec_idx[0][i] > vec_idx[1][j]) begin
                j++;
              end else begin
                r.dot += longint'(vec_val[0][i]) * longint'(vec_val[1][j]);
                i++;
                j++;
              end
            end
          end else begin
            for (j = 0; j < vec_cnt[1]; j++) begin
              for (i = 0; i < vec_cnt[0]; i++) begin
                if (vec_idx[0][i] == vec_idx[1][j])
                  r.dot += longint'(vec_val[0][i]) * longint'(vec_val[1][j]);
              end
            end
          end
        end
        expected_dots.push_back(r);
        clear_vectors();
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    dot_result_t r;
    if (expected_dots.size() == 0) begin
      report_mismatch($sformatf("unexpected result %0d", $signed(out_tdata)));
    end else begin
      r = expected_dots.pop_front();
      if (out_tdata !== r.dot)
        report_mismatch($sformatf("dot_product got %0d exp %0d", $signed(out_tdata), r.dot));
      if (out_tuser[0] !== r.merged)
        report_mismatch($sformatf("took_merge_path got %b exp %b", out_tuser[0], r.merged));
      if (out_tuser[1] !== r.ovf)
        report_mismatch($sformatf("overflow_seen got %b exp %b", out_tuser[1], r.ovf));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (txn_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_txn = txn_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_txn.act;
        in_tdata  <= IN_W'({drv_txn.val, drv_txn.idx});
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_vectors();
    end else begin
      if (in_tvalid && in_tready)
        absorb_transaction(action_t'(in_tuser), in_tdata[IW-1:0], in_tdata[IW+VW-1:IW]);
      if (out_tvalid && out_tready) check_result();
    end
  end

  task automatic push_txn(input action_t act, input logic [IW-1:0] idx,
                          input logic [VW-1:0] val);
    entry_txn_t t;
    t.act = act;
    t.idx = idx;
    t.val = val;
    txn_q.push_back(t);
    if (act != ACT_UNUSED) stim_count++;
  endtask

  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VW-1){1'b0}}};
      1:       return {1'b0, {(VW-1){1'b1}}};
      default: return VW'($urandom);
    endcase
  endfunction

  // fill_vec: -1 for a normal sparse pair, 0 or 1 to overrun that vector's store
  task automatic add_frame(input int fill_vec);
    int            n [2];
    bit            srt [2];
    logic [IW-1:0] nxt [2];
    logic [IW-1:0] idx;
    int unsigned   base;
    int unsigned   span;
    bit            wide;
    int            v;
    wide = ($urandom_range(0, 9) == 0);
    span = $urandom_range(1, 24);
    base = $urandom_range(0, (1 << IW) - 1100);
    for (v = 0; v < 2; v++) begin
      n[v]   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      srt[v] = ($urandom_range(0, 9) < 7);
      nxt[v] = IW'(base + $urandom_range(0, 3));
    end
    if (fill_vec >= 0) begin
      n[fill_vec]     = DEPTH_DEF + $urandom_range(1, 4);
      n[1 - fill_vec] = $urandom_range(1, 4);
    end
    while (n[0] + n[1] > 0) begin
      v = (n[0] == 0) ? 1 : (n[1] == 0) ? 0 : $urandom_range(0, 1);
      if (srt[v]) begin
        idx = nxt[v];
        nxt[v] = nxt[v] + IW'($urandom_range(1, 3));
      end else if (wide) begin
        idx = IW'($urandom);
      end else begin
        idx = IW'(base + $urandom_range(0, span));
      end
      push_txn(v ? ACT_APPEND_B : ACT_APPEND_A, idx, rand_value());
      n[v]--;
      if ($urandom_range(0, 24) == 0) push_txn(ACT_UNUSED, IW'($urandom), VW'($urandom));
    end
    push_txn(ACT_COMPUTE, IW'($urandom), VW'($urandom));
    if ($urandom_range(0, 11) == 0) push_txn(ACT_COMPUTE, IW'($urandom), VW'($urandom));
  endtask

  task automatic fill_phase(input int fill_vec, input int unsigned quota);
    stim_count = 0;
    if (fill_vec >= 0) add_frame(fill_vec);
    while (stim_count < quota) add_frame(-1);
  endtask

  task automatic wait_drained();
    while (txn_q.size() != 0 || in_tvalid || expected_dots.size() != 0) @(negedge clk);
  endtask

  initial begin
    // empty vectors on both sides, then only a loaded
    push_txn(ACT_COMPUTE, '0, '0);
    push_txn(ACT_APPEND_A, 20'hFFFFF, 16'h7FFF);
    push_txn(ACT_COMPUTE, '1, '1);
    push_txn(ACT_UNUSED, 20'hABCDE, 16'h5A5A);
    // both sorted, extreme indices and values
    push_txn(ACT_APPEND_A, 20'h00000, 16'h8000);
    push_txn(ACT_APPEND_A, 20'h00005, 16'h7FFF);
    push_txn(ACT_APPEND_B, 20'h00000, 16'h8000);
    push_txn(ACT_APPEND_A, 20'hFFFFF, 16'hFFFF);
    push_txn(ACT_APPEND_B, 20'h00003, 16'h1234);
    push_txn(ACT_APPEND_B, 20'hFFFFF, 16'h8000);
    push_txn(ACT_COMPUTE, '0, '0);
    // repeated index in a
    push_txn(ACT_APPEND_A, 20'd7, 16'd3);
    push_txn(ACT_APPEND_A, 20'd7, 16'hFFFE);
    push_txn(ACT_APPEND_B, 20'd7, 16'd100);
    push_txn(ACT_COMPUTE, '0, '0);
    // falling index in a
    push_txn(ACT_APPEND_A, 20'd10, 16'd1);
    push_txn(ACT_APPEND_A, 20'd4, 16'd2);
    push_txn(ACT_APPEND_B, 20'd4, 16'd5);
    push_txn(ACT_APPEND_B, 20'd10, 16'd7);
    push_txn(ACT_COMPUTE, '0, '0);
    fill_phase(0, 350);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    send_idle_pct = 67;
    recv_idle_pct = 26;
    fill_phase(1, 370);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_phase(-1, 370);
    wait_drained();

    repeat (300) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/ssdp_pkg.sv
design/ssdp_ram.sv
design/sparse_sparse_dot_product.sv
verif/tb_sparse_sparse_dot_product.sv
